/* design/pcog_pkg.sv */
package pcog_pkg;

  localparam int COL_W    = 6;
  localparam int ROW_W    = 6;
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int COUNT_W  = 16;
  localparam int Z_W      = 24;
  localparam int WORD_W   = COUNT_W + 2 * Z_W;
  localparam int EXT_W    = 7;
  localparam int RAD_W    = 4;
  localparam int CS_W     = 16;
  localparam int QUOT_W   = 6;
  localparam int REM_W    = CS_W + QUOT_W;
  localparam int IN_W     = 88;
  localparam int OUT_W    = 8;

  localparam logic [EXT_W-1:0] MAX_COLS   = 7'd64;
  localparam logic [EXT_W-1:0] MAX_ROWS   = 7'd64;
  localparam logic [RAD_W-1:0] MAX_RADIUS = 4'd8;

  localparam logic [Z_W-1:0] Z_HIGHEST = 24'h7FFFFF;
  localparam logic [Z_W-1:0] Z_LOWEST  = 24'h800000;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CLASS_UNKNOWN  = 2'd0,
    CLASS_OBSTACLE = 2'd1,
    CLASS_FREE     = 2'd2
  } class_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_CELL_SIZE  = 3'd2,
    REG_MAP_WIDTH  = 3'd3,
    REG_MAP_HEIGHT = 3'd4,
    REG_MIN_POINTS = 3'd5,
    REG_HEIGHT_THR = 3'd6,
    REG_DILATE     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [Z_W-1:0]     high_z;
    logic [Z_W-1:0]     low_z;
    logic [COUNT_W-1:0] hit_count;
  } cell_t;

endpackage

/* design/pcog_ram.sv */
module pcog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/point_cloud_occupancy_grid.sv */
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | tuser: kind; tdata: finite, x, y, z, col, row
// out_    | out | out_tvalid/out_tready| tdata: cell_class, out_of_map
// cfg_    | in  | cfg_valid/cfg_ready  | cfg_addr register index, cfg_data value
// one item at a time; an add goes through check, 6-step column/row divide, read, write
// a read goes through check, then, inside the map, a cell read, classify, and neighbor reads
// through the single memory read port when dilation radius r is on and the cell is no obstacle
// a clear sweeps all 4096 entries, one per cycle; the same sweep runs after reset,
// and no word is taken meanwhile; a result waits in an output register while the
// core goes back to idle, so only a second result stalls on out_tready
module point_cloud_occupancy_grid (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pcog_pkg::IN_W-1:0]     in_tdata,   // finite, x, y, z, col, row
  input  logic [1:0]                    in_tuser,   // kind
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pcog_pkg::OUT_W-1:0]    out_tdata,  // cell_class, out_of_map
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_addr,
  input  logic [23:0]                   cfg_data
);
  import pcog_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHK   = 11'b00000000010,
    S_DIV   = 11'b00000000100,
    S_RD    = 11'b00000001000,
    S_WR    = 11'b00000010000,
    S_CRD   = 11'b00000100000,
    S_CCHK  = 11'b00001000000,
    S_SCAN  = 11'b00010000000,
    S_DRAIN = 11'b00100000000,
    S_RESP  = 11'b01000000000,
    S_CLR   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [Z_W-1:0]     origin_x_r, origin_y_r;
  logic [CS_W-1:0]    cell_size_r, min_points_r, height_thr_r;
  logic [EXT_W-1:0]   map_width_r, map_height_r;
  logic [RAD_W-1:0]   dilate_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      cell_size_r  <= 16'd50;
      map_width_r  <= MAX_COLS;
      map_height_r <= MAX_ROWS;
      min_points_r <= 16'd1;
      height_thr_r <= 16'd100;
      dilate_r     <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_ORIGIN_X:   origin_x_r   <= cfg_data;
        REG_ORIGIN_Y:   origin_y_r   <= cfg_data;
        REG_CELL_SIZE:  cell_size_r  <= cfg_data[CS_W-1:0];
        REG_MAP_WIDTH:  map_width_r  <= cfg_data[EXT_W-1:0];
        REG_MAP_HEIGHT: map_height_r <= cfg_data[EXT_W-1:0];
        REG_MIN_POINTS: min_points_r <= cfg_data[CS_W-1:0];
        REG_HEIGHT_THR: height_thr_r <= cfg_data[CS_W-1:0];
        REG_DILATE:     dilate_r     <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  logic [EXT_W-1:0] w_eff, h_eff;
  logic [CS_W-1:0]  cs_eff;
  logic [RAD_W-1:0] r_eff;

  assign w_eff  = (map_width_r > MAX_COLS) ? MAX_COLS : map_width_r;
  assign h_eff  = (map_height_r > MAX_ROWS) ? MAX_ROWS : map_height_r;
  assign cs_eff = (cell_size_r == '0) ? CS_W'(1) : cell_size_r;
  assign r_eff  = (dilate_r > MAX_RADIUS) ? MAX_RADIUS : dilate_r;

  // input word fields
  logic             in_finite;
  logic [Z_W-1:0]   in_x, in_y, in_z;
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;

  assign in_finite = in_tdata[0];
  assign in_x      = in_tdata[24:1];
  assign in_y      = in_tdata[48:25];
  assign in_z      = in_tdata[72:49];
  assign in_col    = in_tdata[78:73];
  assign in_row    = in_tdata[84:79];

  // item registers
  kind_t              kind_r;
  logic signed [Z_W:0] dx_r, dy_r;
  logic [Z_W-1:0]     z_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [REM_W-1:0]   rem_x_r, rem_y_r;
  logic [2:0]         step_r;
  class_t             cls_r;
  logic               oom_r;
  logic               found_r, pend_r;
  logic signed [4:0]  ox_r, oy_r;
  logic [ADDR_W-1:0]  clr_r;

  assign in_tready = (state_r == S_IDLE);

  // memory
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  cell_t             mem_wdata, mem_rdata;

  pcog_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // obstacle test on the word that memory returns
  logic signed [Z_W:0] span;
  logic                rd_obst;
  assign span    = $signed({mem_rdata.high_z[Z_W-1], mem_rdata.high_z})
                 - $signed({mem_rdata.low_z[Z_W-1], mem_rdata.low_z});
  assign rd_obst = (mem_rdata.hit_count != '0) && (mem_rdata.hit_count >= min_points_r)
                 && (span > $signed({9'd0, height_thr_r}));

  // map bounds for the add
  logic [CS_W+EXT_W-1:0] lim_x, lim_y;
  logic                  add_skip;
  assign lim_x    = CS_W'(cs_eff) * w_eff;
  assign lim_y    = CS_W'(cs_eff) * h_eff;
  assign add_skip = dx_r[Z_W] || dy_r[Z_W]
                 || (dx_r[Z_W-1:0] >= {1'b0, lim_x}) || (dy_r[Z_W-1:0] >= {1'b0, lim_y});

  // one quotient bit per cycle; quotient is below 64 after the bound check
  logic [REM_W-1:0] div_d;
  logic             qx_bit, qy_bit;
  assign div_d  = REM_W'(cs_eff) << step_r;
  assign qx_bit = (rem_x_r >= div_d);
  assign qy_bit = (rem_y_r >= div_d);

  // neighbor scan
  logic signed [7:0] nc, nr;
  logic [7:0]        dist2, rad2;
  logic              cand;
  logic              scan_last;
  assign nc    = $signed({2'b00, col_r}) + 8'(ox_r);
  assign nr    = $signed({2'b00, row_r}) + 8'(oy_r);
  assign dist2 = 8'(ox_r * ox_r) + 8'(oy_r * oy_r);
  assign rad2  = 8'(r_eff * r_eff);
  assign cand  = (dist2 <= rad2) && !nc[7] && !nr[7]
              && (nc[6:0] < w_eff) && (nr[6:0] < h_eff);
  assign scan_last = (ox_r == $signed({1'b0, r_eff})) && (oy_r == $signed({1'b0, r_eff}));

  // updated cell
  logic [Z_W-1:0] new_lo, new_hi;
  assign new_lo = ($signed(z_r) < $signed(mem_rdata.low_z)) ? z_r : mem_rdata.low_z;
  assign new_hi = ($signed(z_r) > $signed(mem_rdata.high_z)) ? z_r : mem_rdata.high_z;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {row_r, col_r};
    mem_wdata = mem_rdata;
    mem_raddr = {row_r, col_r};
    unique case (state_r)
      S_WR: begin
        mem_we              = 1'b1;
        mem_wdata.hit_count = (mem_rdata.hit_count == '1) ? mem_rdata.hit_count
                                                          : mem_rdata.hit_count + 1'b1;
        mem_wdata.low_z     = new_lo;
        mem_wdata.high_z    = new_hi;
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '{high_z: Z_LOWEST, low_z: Z_HIGHEST, hit_count: '0};
      end
      S_SCAN: mem_raddr = {nr[ROW_W-1:0], nc[COL_W-1:0]};
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (kind_t'(in_tuser))
            KIND_ADD:   state_nxt = in_finite ? S_CHK : S_IDLE;
            KIND_READ:  state_nxt = S_CHK;
            KIND_CLEAR: state_nxt = S_CLR;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHK: begin
        if (kind_r == KIND_ADD) begin
          state_nxt = add_skip ? S_IDLE : S_DIV;
        end else begin
          state_nxt = ({1'b0, col_r} >= w_eff || {1'b0, row_r} >= h_eff) ? S_RESP : S_CRD;
        end
      end
      S_DIV:   state_nxt = (step_r == '0) ? S_RD : S_DIV;
      S_RD:    state_nxt = S_WR;
      S_WR:    state_nxt = S_IDLE;
      S_CRD:   state_nxt = S_CCHK;
      S_CCHK:  state_nxt = (rd_obst || r_eff == '0) ? S_RESP : S_SCAN;
      S_SCAN:  state_nxt = scan_last ? S_DRAIN : S_SCAN;
      S_DRAIN: state_nxt = S_RESP;
      S_RESP:  state_nxt = (!out_tvalid || out_tready) ? S_IDLE : S_RESP;
      S_CLR:   state_nxt = (clr_r == '1) ? S_IDLE : S_CLR;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == S_SCAN) && cand;
      if (state_r == S_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == S_CCHK) begin
        found_r <= 1'b0;
      end else if (pend_r && rd_obst) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        kind_r <= kind_t'(in_tuser);
        dx_r   <= $signed({in_x[Z_W-1], in_x}) - $signed({origin_x_r[Z_W-1], origin_x_r});
        dy_r   <= $signed({in_y[Z_W-1], in_y}) - $signed({origin_y_r[Z_W-1], origin_y_r});
        z_r    <= in_z;
        col_r  <= in_col;
        row_r  <= in_row;
      end
      S_CHK: begin
        rem_x_r <= dx_r[REM_W-1:0];
        rem_y_r <= dy_r[REM_W-1:0];
        step_r  <= 3'(QUOT_W - 1);
        cls_r   <= CLASS_UNKNOWN;
        oom_r   <= 1'b1;
      end
      S_DIV: begin
        if (qx_bit) rem_x_r <= rem_x_r - div_d;
        if (qy_bit) rem_y_r <= rem_y_r - div_d;
        col_r[step_r] <= qx_bit;
        row_r[step_r] <= qy_bit;
        step_r <= step_r - 1'b1;
      end
      S_CCHK: begin
        oom_r <= 1'b0;
        ox_r  <= -$signed({1'b0, r_eff});
        oy_r  <= -$signed({1'b0, r_eff});
        if (mem_rdata.hit_count == '0) cls_r <= CLASS_UNKNOWN;
        else if (rd_obst)              cls_r <= CLASS_OBSTACLE;
        else                           cls_r <= CLASS_FREE;
      end
      S_SCAN: begin
        if (ox_r == $signed({1'b0, r_eff})) begin
          ox_r <= -$signed({1'b0, r_eff});
          oy_r <= oy_r + 5'sd1;
        end else begin
          ox_r <= ox_r + 5'sd1;
        end
      end
      S_DRAIN: begin
        if (found_r || (pend_r && rd_obst)) cls_r <= CLASS_OBSTACLE;
      end
      default: ;
    endcase
  end

  // output register
  logic         out_valid_r;
  class_t       out_cls_r;
  logic         out_oom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RESP && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESP && (!out_valid_r || out_tready)) begin
      out_cls_r <= cls_r;
      out_oom_r <= oom_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_oom_r, out_cls_r};

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_WR || state_r == S_CLR))
    else $error("memory write outside update or clear");

  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_tready)
    else $error("input taken during clear sweep");

  a_div_inside: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> ({1'b0, col_r} < w_eff && {1'b0, row_r} < h_eff))
    else $error("binned cell outside map");

  a_resp_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP |-> kind_r == KIND_READ)
    else $error("result for a non-read item");

endmodule

/* dv/point_cloud_occupancy_grid_tb.sv */
`timescale 1ns / 1ps

module point_cloud_occupancy_grid_tb;
  import pcog_pkg::*;

  typedef struct {
    class_t     cls;
    logic       oom;
  } cell_answer_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic [1:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [2:0]           cfg_addr = '0;
  logic [23:0]          cfg_data = '0;

  point_cloud_occupancy_grid DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // grid model state
  longint       org_x, org_y;
  int unsigned  cell_mm, cols_cfg, rows_cfg, min_hits, span_thr, radius_cfg;
  int unsigned  hits [DEPTH];
  int           z_lo [DEPTH];
  int           z_hi [DEPTH];

  cell_answer_t answer_q[$];
  int           errors = 0;
  bit           idle_on = 1'b1;
  int           hold_ask = 0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void wipe_grid();
    for (int i = 0; i < DEPTH; i++) begin
      hits[i] = 0;
      z_lo[i] = 8388607;
      z_hi[i] = -8388608;
    end
  endfunction

  function automatic int unsigned used_cols();
    return (cols_cfg > 64) ? 64 : cols_cfg;
  endfunction

  function automatic int unsigned used_rows();
    return (rows_cfg > 64) ? 64 : rows_cfg;
  endfunction

  function automatic bit cell_blocked(int c, int r);
    int i;
    i = r * 64 + c;
    if (hits[i] == 0) return 1'b0;
    return hits[i] >= min_hits && (longint'(z_hi[i]) - longint'(z_lo[i]) > longint'(span_thr));
  endfunction

  function automatic void apply_reg(reg_idx_t idx, logic [23:0] v);
    case (idx)
      REG_ORIGIN_X:   org_x = longint'($signed(v));
      REG_ORIGIN_Y:   org_y = longint'($signed(v));
      REG_CELL_SIZE:  cell_mm = v[15:0];
      REG_MAP_WIDTH:  cols_cfg = v[6:0];
      REG_MAP_HEIGHT: rows_cfg = v[6:0];
      REG_MIN_POINTS: min_hits = v[15:0];
      REG_HEIGHT_THR: span_thr = v[15:0];
      REG_DILATE:     radius_cfg = v[3:0];
      default: ;
    endcase
  endfunction

  // updates the grid model for one accepted word, queues the answer of a read
  function automatic void grid_update(kind_t k, logic fin, logic [23:0] x, logic [23:0] y,
                                      logic [23:0] z, logic [5:0] c, logic [5:0] r);
    longint       cs, dx, dy, zz;
    int           i, rad, nc, nr;
    int unsigned  w, h;
    cell_answer_t a;
    w = used_cols();
    h = used_rows();
    case (k)
      KIND_ADD: begin
        cs = cell_mm ? cell_mm : 1;
        dx = longint'($signed(x)) - org_x;
        dy = longint'($signed(y)) - org_y;
        zz = longint'($signed(z));
        if (fin && dx >= 0 && dy >= 0 && dx / cs < w && dy / cs < h) begin
          i = int'(dy / cs) * 64 + int'(dx / cs);
          if (hits[i] < 65535) hits[i]++;
          if (zz < z_lo[i]) z_lo[i] = int'(zz);
          if (zz > z_hi[i]) z_hi[i] = int'(zz);
        end
      end
      KIND_READ: begin
        a.oom = 1'b0;
        if (c >= w || r >= h) begin
          a.cls = CLASS_UNKNOWN;
          a.oom = 1'b1;
        end else begin
          if (hits[r * 64 + c] == 0) a.cls = CLASS_UNKNOWN;
          else a.cls = cell_blocked(c, r) ? CLASS_OBSTACLE : CLASS_FREE;
          rad = (radius_cfg > 8) ? 8 : radius_cfg;
          if (a.cls != CLASS_OBSTACLE) begin
            for (int oy = -rad; oy <= rad; oy++) begin
              for (int ox = -rad; ox <= rad; ox++) begin
                nc = int'(c) + ox;
                nr = int'(r) + oy;
                if (rad > 0 && ox * ox + oy * oy <= rad * rad && nc >= 0 && nr >= 0 &&
                    nc < w && nr < h && cell_blocked(nc, nr))
                  a.cls = CLASS_OBSTACLE;
              end
            end
          end
        end
        answer_q.push_back(a);
      end
      KIND_CLEAR: wipe_grid();
      default: ;
    endcase
  endfunction

  task automatic send_word(kind_t k, logic fin, logic [23:0] x, logic [23:0] y,
                           logic [23:0] z, logic [5:0] c, logic [5:0] r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {3'b000, r, c, z, y, x, fin};
    do @(posedge clk); while (!in_tready);
    grid_update(k, fin, x, y, z, c, r);
  endtask

  task automatic send_point(longint x, longint y, longint z);
    send_word(KIND_ADD, 1'b1, x[23:0], y[23:0], z[23:0], '0, '0);
  endtask

  task automatic send_read(int c, int r);
    send_word(KIND_READ, 1'($urandom_range(0, 1)), 24'($urandom), 24'($urandom),
              24'($urandom), c[5:0], r[5:0]);
  endtask

  task automatic send_clear();
    send_word(KIND_CLEAR, 1'b0, '0, '0, '0, '0, '0);
  endtask

  // only written once the grid has drained; adds and clears give no answer, so wait out a sweep
  task automatic write_reg(reg_idx_t idx, logic [23:0] v);
    in_tvalid <= 1'b0;
    wait (answer_q.size() == 0);
    repeat (4200) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, v);
  endtask

  task automatic set_grid(longint ox, longint oy, int cs, int w, int h, int mp, int thr, int rad);
    write_reg(REG_ORIGIN_X, ox[23:0]);
    write_reg(REG_ORIGIN_Y, oy[23:0]);
    write_reg(REG_CELL_SIZE, cs[23:0]);
    write_reg(REG_MAP_WIDTH, w[23:0]);
    write_reg(REG_MAP_HEIGHT, h[23:0]);
    write_reg(REG_MIN_POINTS, mp[23:0]);
    write_reg(REG_HEIGHT_THR, thr[23:0]);
    write_reg(REG_DILATE, rad[23:0]);
  endtask

  // checker for the answer stream
  always @(posedge clk) begin
    cell_answer_t a;
    if (rst_n && out_tvalid && out_tready) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected answer word", int'(out_tdata), -1);
      end else begin
        a = answer_q.pop_front();
        if (out_tdata[1:0] !== a.cls) report_mismatch("cell_class", out_tdata[1:0], a.cls);
        if (out_tdata[2] !== a.oom) report_mismatch("out_of_map", out_tdata[2], a.oom);
      end
    end
  end

  // answer side flow control; a long hold fills the block up
  always @(posedge clk) begin
    static int hold_seen = 0;
    static int hold_left = 0;
    static int stall_left = 0;
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic test_directed();
    send_point(0, 0, -200);
    send_point(49, 49, 200);
    send_read(0, 0);
    send_point(3199, 3199, 0);
    send_read(63, 63);
    send_point(3200, 10, 500);
    send_point(-1, 10, 500);
    send_word(KIND_ADD, 1'b0, 24'd100, 24'd100, 24'h7FFFFF, '0, '0);
    send_read(2, 2);
    send_point(8388607, 8388607, 8388607);
    send_point(-8388608, -8388608, -8388608);
    send_word(KIND_NONE, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 6'h3F, 6'h3F);
    send_read(63, 0);
    send_clear();
    send_read(0, 0);
    send_read(63, 63);
  endtask

  task automatic test_extents();
    set_grid(0, 0, 10, 10, 5, 1, 100, 0);
    send_point(95, 45, 0);
    send_read(9, 4);
    send_read(10, 0);
    send_read(0, 5);
    send_read(63, 63);
    write_reg(REG_MAP_WIDTH, 24'd127);
    write_reg(REG_MAP_HEIGHT, 24'd100);
    send_point(639, 639, 0);
    send_read(63, 63);
    write_reg(REG_MAP_WIDTH, 24'd0);
    send_point(5, 5, 0);
    send_read(0, 0);
    write_reg(REG_MAP_WIDTH, 24'd64);
    write_reg(REG_CELL_SIZE, 24'hFF0000);
    send_point(7, 3, -1000);
    send_point(7, 3, 1000);
    send_read(7, 3);
    write_reg(REG_DILATE, 24'd15);
    send_read(15, 3);
    send_read(16, 3);
    send_read(7, 12);
    write_reg(REG_HEIGHT_THR, 24'd65535);
    send_read(7, 3);
    write_reg(REG_CELL_SIZE, 24'd65535);
    write_reg(REG_ORIGIN_X, 24'h800000);
    write_reg(REG_ORIGIN_Y, 24'h7FFFFF);
    send_point(-8388608, 8388607, 0);
    send_point(8388607, -8388608, 0);
    send_read(0, 0);
    send_clear();
  endtask

  task automatic test_min_points();
    idle_on = 1'b0;
    set_grid(0, 0, 50, 64, 64, 20, 0, 0);
    for (int i = 0; i < 20; i++) send_point(25, 25, (i % 2) ? 10 : -10);
    send_read(0, 0);
    write_reg(REG_HEIGHT_THR, 24'd20);
    send_read(0, 0);
    write_reg(REG_HEIGHT_THR, 24'd19);
    send_read(0, 0);
    write_reg(REG_MIN_POINTS, 24'd21);
    send_read(0, 0);
    send_clear();
    idle_on = 1'b1;
  endtask

  task automatic random_phase(int n, int max_rad);
    longint       ox, oy, x, y;
    int           cs, w, h, c, r, pick;
    ox = longint'($signed(24'($urandom))) / ($urandom_range(0, 1) ? 1 : 4096);
    oy = longint'($signed(24'($urandom))) / ($urandom_range(0, 1) ? 1 : 4096);
    cs = $urandom_range(0, 3) == 0 ? $urandom_range(1, 65535) : $urandom_range(1, 200);
    w  = $urandom_range(1, 64);
    h  = $urandom_range(1, 64);
    set_grid(ox, oy, cs, w, h, $urandom_range(1, 4), $urandom_range(0, 300),
             $urandom_range(0, max_rad));
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        x = ox + longint'($urandom_range(0, (w + 1) * cs)) - cs / 2;
        y = oy + longint'($urandom_range(0, (h + 1) * cs)) - cs / 2;
        if (x > 8388607 || x < -8388608) x = longint'($signed(24'($urandom)));
        if (y > 8388607 || y < -8388608) y = longint'($signed(24'($urandom)));
        send_point(x, y, $urandom_range(0, 3) == 0 ? longint'($signed(24'($urandom)))
                                                    : longint'($urandom_range(0, 500)) - 250);
      end else if (pick < 62) begin
        send_word(KIND_ADD, 1'($urandom_range(0, 1)), 24'($urandom), 24'($urandom),
                  24'($urandom), 6'($urandom), 6'($urandom));
      end else if (pick < 96) begin
        c = $urandom_range(0, 7) == 0 ? $urandom_range(0, 63) : $urandom_range(0, w);
        r = $urandom_range(0, 7) == 0 ? $urandom_range(0, 63) : $urandom_range(0, h);
        send_read(c > 63 ? 63 : c, r > 63 ? 63 : r);
      end else if (pick < 98) begin
        send_word(KIND_NONE, 1'($urandom_range(0, 1)), 24'($urandom), 24'($urandom),
                  24'($urandom), 6'($urandom), 6'($urandom));
      end else begin
        send_clear();
      end
    end
  endtask

  task automatic test_backpressure();
    set_grid(0, 0, 20, 16, 16, 1, 50, 0);
    send_point(10, 10, -100);
    send_point(10, 10, 100);
    hold_ask++;
    for (int k = 0; k < 12; k++) send_read($urandom_range(0, 3), $urandom_range(0, 3));
  endtask

  initial begin
    org_x = 0; org_y = 0; cell_mm = 50; cols_cfg = 64; rows_cfg = 64;
    min_hits = 1; span_thr = 100; radius_cfg = 0;
    wipe_grid();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_extents();
    test_min_points();
    test_backpressure();
    random_phase(100, 2);
    random_phase(100, 0);
    random_phase(90, 4);
    random_phase(30, 8);
    random_phase(100, 1);
    idle_on = 1'b0;
    random_phase(50, 2);
    in_tvalid <= 1'b0;
    wait (answer_q.size() == 0);
    repeat (4200) @(posedge clk);
    if (errors == 0) begin
      $display("** point_cloud_occupancy_grid: PASSED **");
    end else begin
      $display("** point_cloud_occupancy_grid: FAILED **");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d answers pending", answer_q.size());
    $display("** point_cloud_occupancy_grid: FAILED **");
    $finish;
  end

endmodule
